@@ hw/rtl/nhc_pkg.sv @@
// ----------------------------------------------------------------------------
// nhc_pkg
// types, codes and helpers shared by the nucleotide huffman codec
// ----------------------------------------------------------------------------
package nhc_pkg;

  localparam int NUM_SYMS  = 4;
  localparam int NUM_NODES = 7;
  localparam int NODE_W    = 3;
  localparam int SYM_W     = 2;

  localparam logic [2:0] MODE_CLEAR  = 3'd0;
  localparam logic [2:0] MODE_COUNT  = 3'd1;
  localparam logic [2:0] MODE_ENCODE = 3'd2;
  localparam logic [2:0] MODE_DECODE = 3'd3;
  localparam logic [2:0] MODE_LOAD   = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR   = 3'd1;
  localparam logic [2:0] ST_UNCODED    = 3'd2;
  localparam logic [2:0] ST_BAD_CODE   = 3'd3;
  localparam logic [2:0] ST_INCOMPLETE = 3'd4;

  localparam logic [7:0] SYM_CHAR [NUM_SYMS] = '{8'h41, 8'h43, 8'h47, 8'h54};

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INIT,
    S_SCAN,
    S_TAKE,
    S_CODES
  } state_t;

  typedef struct packed {
    logic ready;
    logic exec;
    logic build_init;
    logic scan_step;
    logic take;
    logic codes;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic unused;
    logic needs_build;
    logic out_free;
    logic few_leaves;
    logic scan_last;
    logic take_again;
  } stat_t;

  // returns {valid, index}
  function automatic logic [SYM_W:0] sym_lookup(input logic [7:0] c);
    logic [SYM_W:0] r;
    r = '0;
    for (int i = 0; i < NUM_SYMS; i++) begin
      if (c == SYM_CHAR[i]) begin
        r = {1'b1, SYM_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/nhc_in_if.sv @@
// ----------------------------------------------------------------------------
// nhc_in_if
// item channel into the codec
// ----------------------------------------------------------------------------
interface nhc_in_if import nhc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  char_in;
  logic        bit_in;
  logic [31:0] count_value;
  logic        end_of_bits;

  modport source (output valid, mode, char_in, bit_in, count_value, end_of_bits,
                  input ready);
  modport sink (input valid, mode, char_in, bit_in, count_value, end_of_bits,
                output ready);
endinterface

@@ hw/rtl/nhc_out_if.sv @@
// ----------------------------------------------------------------------------
// nhc_out_if
// result channel out of the codec
// ----------------------------------------------------------------------------
interface nhc_out_if import nhc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] code_bits;
  logic [1:0] code_length;
  logic       symbol_valid;
  logic [7:0] symbol_out;

  modport source (output valid, status, code_bits, code_length, symbol_valid,
                  symbol_out, input ready);
  modport sink (input valid, status, code_bits, code_length, symbol_valid,
                symbol_out, output ready);
endinterface

@@ hw/rtl/nucleotide_huffman_codec_top.sv @@
// an item is transferred in, then executed into the result register
// the first encode or decode after a count change first builds the code tree
// on one shared compare unit, by node scans and merges
// the result register frees the output side; a new item is taken once the
// previous one has executed. synchronous reset clears counts, codes and control
// ----------------------------------------------------------------------------
// nucleotide_huffman_codec_top
// four symbol huffman counter, encoder and decoder
// ----------------------------------------------------------------------------
module nucleotide_huffman_codec_top import nhc_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  nhc_in_if.sink    req,
  nhc_out_if.source rsp
);

  cmd_t  cmd;
  stat_t st;

  nhc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  nhc_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .st  (st),
    .req (req),
    .rsp (rsp)
  );

endmodule

@@ hw/rtl/nhc_ctrl.sv @@
// ----------------------------------------------------------------------------
// nhc_ctrl
// sequencer for item execution and code tree build
// ----------------------------------------------------------------------------
module nhc_ctrl import nhc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (st.in_fire) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (st.unused) begin
          state_next = S_IDLE;
        end else if (st.needs_build) begin
          state_next = S_INIT;
        end else if (st.out_free) begin
          cmd.exec = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_INIT: begin
        cmd.build_init = 1'b1;
        state_next = st.few_leaves ? S_CODES : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) state_next = S_TAKE;
      end
      S_TAKE: begin
        cmd.take = 1'b1;
        state_next = st.take_again ? S_SCAN : S_CODES;
      end
      S_CODES: begin
        cmd.codes = 1'b1;
        state_next = S_EXEC;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/nhc_datapath.sv @@
// ----------------------------------------------------------------------------
// nhc_datapath
// counts, node table, code tables, decode shifter and result register
// ----------------------------------------------------------------------------
module nhc_datapath import nhc_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output stat_t st,
  nhc_in_if.sink   req,
  nhc_out_if.source rsp
);

  localparam int FW = (COUNT_WIDTH + 2 > 64) ? 64 : COUNT_WIDTH + 2;
  localparam int VW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  // latched item
  logic [2:0]  mode;
  logic [7:0]  char_in;
  logic        bit_in;
  logic [31:0] count_value;
  logic        end_of_bits;

  logic [COUNT_WIDTH-1:0] counts [NUM_SYMS];
  logic [2:0] code_words [NUM_SYMS];
  logic [1:0] code_lengths [NUM_SYMS];
  logic       codes_current;
  logic [1:0] longest_code;
  logic [2:0] pending_bits;
  logic [1:0] pending_length;

  // build table
  logic [FW-1:0]     freq [NUM_NODES];
  logic [NUM_NODES-1:0] live;
  logic [NUM_NODES-1:0] pvalid;
  logic [NODE_W-1:0] parent [NUM_NODES];
  logic [NUM_NODES-1:0] branch;
  logic [NODE_W-1:0] made;
  logic [2:0]        leaves;
  logic [NODE_W-1:0] scan_idx;
  logic              have_best;
  logic [NODE_W-1:0] best;
  logic [FW-1:0]     best_freq;
  logic              pick;
  logic [NODE_W-1:0] node_a;
  logic [FW-1:0]     a_freq;

  logic          out_valid;
  logic [SYM_W:0] look;
  logic [SYM_W-1:0] idx;
  logic          idx_ok;
  logic [2:0]    nz_count;
  logic [FW:0]   sum;
  logic [FW-1:0] sum_sat;
  logic [FW-1:0] scan_freq;
  logic          better;

  assign look   = sym_lookup(char_in);
  assign idx    = look[SYM_W-1:0];
  assign idx_ok = look[SYM_W];
  assign req.ready = cmd.ready;

  always_comb begin
    nz_count = '0;
    for (int i = 0; i < NUM_SYMS; i++) begin
      nz_count = nz_count + 3'(counts[i] != '0);
    end
  end

  assign sum       = {1'b0, a_freq} + {1'b0, best_freq};
  assign sum_sat   = sum[FW] ? {FW{1'b1}} : sum[FW-1:0];
  assign scan_freq = freq[scan_idx];
  assign better    = live[scan_idx] && (!have_best || scan_freq < best_freq);

  always_comb begin
    st.in_fire     = req.valid && req.ready;
    st.unused      = mode > MODE_LOAD;
    st.needs_build = !codes_current &&
                     ((mode == MODE_ENCODE && idx_ok) || mode == MODE_DECODE);
    st.out_free    = !out_valid || rsp.ready;
    st.few_leaves  = nz_count <= 3'd1;
    st.scan_last   = scan_idx == made - NODE_W'(1);
    st.take_again  = !pick || (leaves > 3'd2);
  end

  // code walk over the finished tree
  logic [2:0] w_word [NUM_SYMS];
  logic [1:0] w_len  [NUM_SYMS];
  logic [1:0] w_long;
  always_comb begin
    logic [NODE_W-1:0] node;
    logic              go;
    w_long = '0;
    for (int i = 0; i < NUM_SYMS; i++) begin
      w_word[i] = '0;
      w_len[i]  = '0;
      node = NODE_W'(i);
      go   = counts[i] != '0;
      if (nz_count == 3'd1) begin
        if (go) w_len[i] = 2'd1;
      end else begin
        for (int d = 0; d < 3; d++) begin
          if (go && pvalid[node]) begin
            w_word[i] = w_word[i] | (3'(branch[node]) << d);
            w_len[i]  = w_len[i] + 2'd1;
            node      = parent[node];
          end else begin
            go = 1'b0;
          end
        end
      end
      if (w_len[i] > w_long) w_long = w_len[i];
    end
  end

  // decode step
  logic [2:0] d_bits;
  logic [2:0] d_len;
  logic       d_hit;
  logic [7:0] d_sym;
  always_comb begin
    d_bits = {pending_bits[1:0], bit_in};
    d_len  = {1'b0, pending_length} + 3'd1;
    d_hit  = 1'b0;
    d_sym  = '0;
    for (int i = NUM_SYMS - 1; i >= 0; i--) begin
      if (code_lengths[i] != '0 && {1'b0, code_lengths[i]} == d_len &&
          code_words[i] == d_bits) begin
        d_hit = 1'b1;
        d_sym = SYM_CHAR[i];
      end
    end
  end

  logic [VW-1:0] v_ext;
  assign v_ext = VW'(count_value);

  always_ff @(posedge clk) begin
    if (st.in_fire) begin
      mode        <= req.mode;
      char_in     <= req.char_in;
      bit_in      <= req.bit_in;
      count_value <= req.count_value;
      end_of_bits <= req.end_of_bits;
    end
  end

  // build table
  always_ff @(posedge clk) begin
    if (cmd.build_init) begin
      for (int i = 0; i < NUM_SYMS; i++) begin
        freq[i] <= FW'(counts[i]);
        live[i] <= counts[i] != '0;
      end
      for (int i = NUM_SYMS; i < NUM_NODES; i++) live[i] <= 1'b0;
      pvalid    <= '0;
      made      <= NODE_W'(NUM_SYMS);
      leaves    <= nz_count;
      scan_idx  <= '0;
      have_best <= 1'b0;
      pick      <= 1'b0;
    end else if (cmd.scan_step) begin
      if (better) begin
        best      <= scan_idx;
        best_freq <= scan_freq;
        have_best <= 1'b1;
      end
      scan_idx <= scan_idx + NODE_W'(1);
    end else if (cmd.take) begin
      live[best] <= 1'b0;
      scan_idx   <= '0;
      have_best  <= 1'b0;
      if (!pick) begin
        node_a <= best;
        a_freq <= best_freq;
        pick   <= 1'b1;
      end else begin
        freq[made]     <= sum_sat;
        live[made]     <= 1'b1;
        parent[node_a] <= made;
        pvalid[node_a] <= 1'b1;
        branch[node_a] <= 1'b0;
        parent[best]   <= made;
        pvalid[best]   <= 1'b1;
        branch[best]   <= 1'b1;
        made           <= made + NODE_W'(1);
        leaves         <= leaves - 3'd1;
        pick           <= 1'b0;
      end
    end
  end

  // architectural state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SYMS; i++) begin
        counts[i]       <= '0;
        code_words[i]   <= '0;
        code_lengths[i] <= '0;
      end
      codes_current  <= 1'b0;
      longest_code   <= '0;
      pending_bits   <= '0;
      pending_length <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (rsp.ready) out_valid <= 1'b0;
      if (cmd.codes) begin
        for (int i = 0; i < NUM_SYMS; i++) begin
          code_words[i]   <= w_word[i];
          code_lengths[i] <= w_len[i];
        end
        longest_code   <= w_long;
        codes_current  <= 1'b1;
        pending_bits   <= '0;
        pending_length <= '0;
      end
      if (cmd.exec) begin
        out_valid        <= 1'b1;
        rsp.status       <= ST_OK;
        rsp.code_bits    <= '0;
        rsp.code_length  <= '0;
        rsp.symbol_valid <= 1'b0;
        rsp.symbol_out   <= '0;
        case (mode)
          MODE_CLEAR: begin
            for (int i = 0; i < NUM_SYMS; i++) begin
              counts[i]       <= '0;
              code_words[i]   <= '0;
              code_lengths[i] <= '0;
            end
            codes_current  <= 1'b0;
            longest_code   <= '0;
            pending_bits   <= '0;
            pending_length <= '0;
          end
          MODE_COUNT, MODE_LOAD: begin
            if (!idx_ok) begin
              rsp.status <= ST_BAD_CHAR;
            end else begin
              codes_current <= 1'b0;
              if (mode == MODE_COUNT) begin
                if (counts[idx] != CMAX) counts[idx] <= counts[idx] + COUNT_WIDTH'(1);
              end else if (v_ext > VW'(CMAX)) begin
                counts[idx] <= CMAX;
              end else begin
                counts[idx] <= COUNT_WIDTH'(v_ext);
              end
            end
          end
          MODE_ENCODE: begin
            if (!idx_ok) begin
              rsp.status <= ST_BAD_CHAR;
            end else if (code_lengths[idx] == '0) begin
              rsp.status <= ST_UNCODED;
            end else begin
              rsp.code_bits   <= code_words[idx];
              rsp.code_length <= code_lengths[idx];
            end
          end
          MODE_DECODE: begin
            if (d_hit) begin
              rsp.symbol_valid <= 1'b1;
              rsp.symbol_out   <= d_sym;
              pending_bits     <= '0;
              pending_length   <= '0;
            end else if (d_len > {1'b0, longest_code} || d_len >= 3'd3) begin
              rsp.status     <= ST_BAD_CODE;
              pending_bits   <= '0;
              pending_length <= '0;
            end else if (end_of_bits) begin
              rsp.status     <= ST_INCOMPLETE;
              pending_bits   <= '0;
              pending_length <= '0;
            end else begin
              pending_bits   <= d_bits;
              pending_length <= d_len[1:0];
            end
          end
          default: out_valid <= 1'b0;
        endcase
      end
    end
  end

  assign rsp.valid = out_valid;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// codec check: directed table then random clears, counts, loads, encodes and decodes,
// each result compared with an in-bench huffman code predictor
// ----------------------------------------------------------------------------
module tb_top;
  import nhc_pkg::*;

  typedef struct {
    logic [2:0]  mode;
    logic [7:0]  ch;
    logic        bit_v;
    logic [31:0] value;
    logic        eob;
  } item_t;

  typedef struct {
    logic [2:0] status;
    logic [2:0] cbits;
    logic [1:0] clen;
    logic       svalid;
    logic [7:0] sout;
  } answer_t;

  typedef struct {
    item_t   it;
    bit      has_exp;
    answer_t exp;
  } row_t;

  localparam logic [7:0] NUC [4] = '{8'h41, 8'h43, 8'h47, 8'h54};
  localparam int LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  always #2 clk = ~clk;

  nhc_in_if  req ();
  nhc_out_if rsp ();

  nucleotide_huffman_codec_top DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  logic [31:0] counts [4];
  logic [2:0]  words [4];
  logic [1:0]  lens [4];
  bit          fresh;
  logic [1:0]  deepest;
  logic [2:0]  pend;
  int          pend_n;
  answer_t     expected_q [$];
  int          errors = 0;
  int          cycles = 0;

  function automatic int nuc_index(logic [7:0] c);
    for (int i = 0; i < 4; i++) if (c == NUC[i]) return i;
    return -1;
  endfunction

  function automatic void wipe_codec();
    for (int i = 0; i < 4; i++) begin
      counts[i] = 0; words[i] = 0; lens[i] = 0;
    end
    fresh = 0; deepest = 0; pend = 0; pend_n = 0;
  endfunction

  function automatic void build_tree();
    logic [63:0] fr [7];
    bit live [7];
    int par [7];
    bit br [7];
    int leaves, made, a, b, node, d;
    logic [2:0] w;
    leaves = 0; made = 4;
    for (int i = 0; i < 7; i++) begin
      fr[i] = 0; live[i] = 0; par[i] = -1; br[i] = 0;
    end
    for (int i = 0; i < 4; i++) begin
      words[i] = 0; lens[i] = 0; fr[i] = 64'(counts[i]);
      if (counts[i] != 0) begin
        live[i] = 1; leaves++;
      end
    end
    deepest = 0;
    if (leaves == 1) begin
      for (int i = 0; i < 4; i++) if (live[i]) lens[i] = 1;
      deepest = 1;
    end else if (leaves > 1) begin
      while (leaves > 1 && made < 7) begin
        a = -1;
        for (int i = 0; i < made; i++)
          if (live[i] && (a < 0 || fr[i] < fr[a])) a = i;
        live[a] = 0;
        b = -1;
        for (int i = 0; i < made; i++)
          if (live[i] && (b < 0 || fr[i] < fr[b])) b = i;
        live[b] = 0;
        fr[made] = (fr[a] + fr[b] < fr[a]) ? '1 : fr[a] + fr[b];
        par[a] = made; br[a] = 0; par[b] = made; br[b] = 1;
        live[made] = 1; made++; leaves--;
      end
      for (int i = 0; i < 4; i++) begin
        if (counts[i] == 0) continue;
        node = i; d = 0; w = 0;
        while (par[node] >= 0 && d < 3) begin
          w = w | (3'(br[node]) << d);
          d++; node = par[node];
        end
        words[i] = w; lens[i] = 2'(d);
        if (2'(d) > deepest) deepest = 2'(d);
      end
    end
    fresh = 1; pend = 0; pend_n = 0;
  endfunction

  function automatic bit codec_step(item_t it, output answer_t r);
    int idx;
    bit hit;
    r = '{default: 0};
    idx = nuc_index(it.ch);
    if (it.mode > MODE_LOAD) return 0;
    case (it.mode)
      MODE_CLEAR: wipe_codec();
      MODE_COUNT, MODE_LOAD: begin
        if (idx < 0) r.status = ST_BAD_CHAR;
        else begin
          if (it.mode == MODE_COUNT) begin
            if (counts[idx] != '1) counts[idx]++;
          end else counts[idx] = it.value;
          fresh = 0;
        end
      end
      MODE_ENCODE: begin
        if (idx < 0) r.status = ST_BAD_CHAR;
        else begin
          if (!fresh) build_tree();
          if (lens[idx] == 0) r.status = ST_UNCODED;
          else begin
            r.cbits = words[idx]; r.clen = lens[idx];
          end
        end
      end
      default: begin
        hit = 0;
        if (!fresh) build_tree();
        pend = {pend[1:0], it.bit_v};
        pend_n++;
        for (int i = 0; i < 4; i++) begin
          if (!hit && lens[i] != 0 && lens[i] == pend_n && words[i] == pend) begin
            hit = 1; r.svalid = 1; r.sout = NUC[i];
          end
        end
        if (hit) begin
          pend = 0; pend_n = 0;
        end else if (pend_n > deepest || pend_n >= 3) begin
          r.status = ST_BAD_CODE; pend = 0; pend_n = 0;
        end
        if (it.eob && pend_n != 0) begin
          r.status = ST_INCOMPLETE; pend = 0; pend_n = 0;
        end
      end
    endcase
    return 1;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // send one item, predicting its answer when accepted
  task automatic send(row_t rw);
    answer_t r;
    int g;
    g = gap_len();
    if (g > 0) begin
      req.valid <= 0;
      repeat (g) @(posedge clk);
    end
    req.valid <= 1;
    req.mode <= rw.it.mode;
    req.char_in <= rw.it.ch;
    req.bit_in <= rw.it.bit_v;
    req.count_value <= rw.it.value;
    req.end_of_bits <= rw.it.eob;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (codec_step(rw.it, r)) begin
      if (rw.has_exp && r != rw.exp) begin
        $error("table row disagrees with predictor for mode %0d", rw.it.mode);
        errors++;
      end
      expected_q.push_back(r);
    end
  endtask

  function automatic item_t mk(logic [2:0] m, logic [7:0] c, logic b,
                               logic [31:0] v, logic e);
    item_t it;
    it.mode = m; it.ch = c; it.bit_v = b; it.value = v; it.eob = e;
    return it;
  endfunction

  function automatic answer_t ans(logic [2:0] s);
    answer_t a;
    a = '{default: 0};
    a.status = s;
    return a;
  endfunction

  // random item biased toward nucleotides and decodes of random bits
  function automatic item_t rand_item();
    int p;
    logic [7:0] c;
    logic [31:0] v;
    p = $urandom_range(0, 99);
    c = ($urandom_range(0, 9) == 0) ? 8'($urandom) : NUC[$urandom_range(0, 3)];
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 20);
      1: v = $urandom;
      2: v = 32'hffffffff - $urandom_range(0, 3);
      default: v = 32'h1 << $urandom_range(0, 31);
    endcase
    if (p < 2) return mk(MODE_CLEAR, c, 1'($urandom), $urandom, 1'($urandom));
    if (p < 25) return mk(MODE_COUNT, c, 1'($urandom), $urandom, 1'($urandom));
    if (p < 35) return mk(MODE_LOAD, c, 1'($urandom), v, 1'($urandom));
    if (p < 60) return mk(MODE_ENCODE, c, 1'($urandom), $urandom, 1'($urandom));
    if (p < 97) return mk(MODE_DECODE, 8'($urandom), 1'($urandom), $urandom,
                          $urandom_range(0, 7) == 0);
    return mk(3'($urandom_range(5, 7)), c, 1'($urandom), $urandom, 1'($urandom));
  endfunction

  // result side: random stalls and compare against predictions
  initial begin
    answer_t e;
    rsp.ready = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (rsp.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, rsp.status); errors++;
          end
          if (rsp.code_bits !== e.cbits) begin
            $error("code_bits exp %0d got %0d", e.cbits, rsp.code_bits); errors++;
          end
          if (rsp.code_length !== e.clen) begin
            $error("code_length exp %0d got %0d", e.clen, rsp.code_length); errors++;
          end
          if (rsp.symbol_valid !== e.svalid) begin
            $error("symbol_valid exp %0d got %0d", e.svalid, rsp.symbol_valid);
            errors++;
          end
          if (rsp.symbol_out !== e.sout) begin
            $error("symbol_out exp %h got %h", e.sout, rsp.symbol_out); errors++;
          end
        end
      end
      if (cycles < 20000 && (cycles / 700) % 3 == 0) rsp.ready <= 1;
      else rsp.ready <= (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("nucleotide_huffman_codec_top test failed");
      $finish;
    end
  end

  initial begin
    row_t tbl [$];
    row_t rw;
    int wait_n;
    req.valid = 0; req.mode = MODE_CLEAR; req.char_in = 0; req.bit_in = 0;
    req.count_value = 0; req.end_of_bits = 0;
    wipe_codec();
    repeat (3) @(posedge clk);
    rst <= 0;

    tbl.push_back('{mk(MODE_DECODE, 0, 1, 0, 0), 1, ans(ST_BAD_CODE)});
    tbl.push_back('{mk(MODE_ENCODE, NUC[0], 0, 0, 0), 1, ans(ST_UNCODED)});
    tbl.push_back('{mk(MODE_COUNT, 8'hff, 0, 0, 0), 1, ans(ST_BAD_CHAR)});
    tbl.push_back('{mk(MODE_LOAD, 8'h00, 0, '1, 0), 1, ans(ST_BAD_CHAR)});
    tbl.push_back('{mk(MODE_ENCODE, 8'h61, 0, 0, 0), 1, ans(ST_BAD_CHAR)});
    tbl.push_back('{mk(3'd5, NUC[0], 0, 0, 0), 0, ans(ST_OK)});
    tbl.push_back('{mk(3'd7, NUC[1], 1, '1, 1), 0, ans(ST_OK)});
    tbl.push_back('{mk(MODE_COUNT, NUC[2], 0, 0, 0), 1, ans(ST_OK)});
    tbl.push_back('{mk(MODE_ENCODE, NUC[2], 0, 0, 0), 0, ans(ST_OK)});
    tbl.push_back('{mk(MODE_DECODE, 0, 0, 0, 1), 0, ans(ST_OK)});
    tbl.push_back('{mk(MODE_DECODE, 0, 1, 0, 0), 1, ans(ST_OK)});
    tbl.push_back('{mk(MODE_LOAD, NUC[0], 0, 32'hffffffff, 0), 1, ans(ST_OK)});
    tbl.push_back('{mk(MODE_COUNT, NUC[0], 0, 0, 0), 1, ans(ST_OK)});
    tbl.push_back('{mk(MODE_LOAD, NUC[1], 0, 32'hffffffff, 0), 1, ans(ST_OK)});
    tbl.push_back('{mk(MODE_LOAD, NUC[3], 0, 1, 0), 1, ans(ST_OK)});
    tbl.push_back('{mk(MODE_ENCODE, NUC[3], 0, 0, 0), 0, ans(ST_OK)});
    tbl.push_back('{mk(MODE_ENCODE, NUC[0], 0, 0, 0), 0, ans(ST_OK)});
    tbl.push_back('{mk(MODE_DECODE, 0, 1, 0, 0), 0, ans(ST_OK)});
    tbl.push_back('{mk(MODE_DECODE, 0, 1, 0, 1), 0, ans(ST_OK)});
    tbl.push_back('{mk(MODE_DECODE, 0, 0, 0, 0), 0, ans(ST_OK)});
    tbl.push_back('{mk(MODE_DECODE, 0, 0, 0, 0), 0, ans(ST_OK)});
    tbl.push_back('{mk(MODE_DECODE, 0, 0, 0, 0), 0, ans(ST_OK)});
    tbl.push_back('{mk(MODE_CLEAR, 0, 0, 0, 0), 1, ans(ST_OK)});
    foreach (tbl[i]) send(tbl[i]);

    for (int n = 0; n < 900; n++) begin
      if (n == 450) begin
        // hold off until the block has drained
        req.valid <= 0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
      end
      rw.it = rand_item();
      rw.has_exp = 0;
      send(rw);
    end
    req.valid <= 0;

    wait_n = 0;
    while (expected_q.size() != 0 && wait_n < 100000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("nucleotide_huffman_codec_top test passed");
    end else begin
      $display("nucleotide_huffman_codec_top test failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/nhc_pkg.sv
hw/rtl/nhc_in_if.sv
hw/rtl/nhc_out_if.sv
hw/rtl/nhc_ctrl.sv
hw/rtl/nhc_datapath.sv
hw/rtl/nucleotide_huffman_codec_top.sv
dv/tb_top.sv
